// ===== rtl/cpd_pkg.sv =====
`timescale 1ns / 1ps

package cpd_pkg;

  // Longest frame the buffer counts before it drops a byte and restarts.
  localparam int FRAME_LIMIT = 20;

  localparam logic [15:0] TIMEOUT_RESET = 16'd500;
  localparam logic [4:0]  LEN_BUTTON    = 5'd5;
  localparam logic [4:0]  LEN_COLOR     = 5'd6;

  localparam logic [7:0] CH_START  = 8'h21;  // '!'
  localparam logic [7:0] CH_BUTTON = 8'h42;  // 'B'
  localparam logic [7:0] CH_COLOR  = 8'h43;  // 'C'
  localparam logic [7:0] CH_ZERO   = 8'h30;  // '0'
  localparam logic [7:0] CH_ONE    = 8'h31;  // '1'
  localparam logic [7:0] CH_EIGHT  = 8'h38;  // '8'

  typedef enum logic [1:0] {
    CMD_BYTE = 2'd0,
    CMD_TICK = 2'd1,
    CMD_ACK  = 2'd2,
    CMD_NOP  = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    KIND_NONE   = 2'd0,
    KIND_COLOR  = 2'd1,
    KIND_BUTTON = 2'd2,
    KIND_RSVD   = 2'd3
  } kind_e;

  typedef struct packed {
    logic [1:0] command;
    logic [7:0] rx_byte;
  } cpd_in_t;

  typedef struct packed {
    logic       packet_done;
    logic [1:0] packet_kind;
    logic [7:0] color_red;
    logic [7:0] color_green;
    logic [7:0] color_blue;
    logic [7:0] button_bits;
    logic       update_flag;
    logic       timed_out;
  } cpd_out_t;

  typedef struct packed {
    logic [4:0]      byte_index;
    logic [7:0]      frame_type;
    logic [2:0][7:0] payload;
    logic [15:0]     idle_count;
    logic [7:0]      red_level;
    logic [7:0]      green_level;
    logic [7:0]      blue_level;
    logic [7:0]      pressed_buttons;
    logic            update_pending;
  } cpd_state_t;

endpackage

// ===== rtl/controller_packet_deframer_unit.sv =====
`timescale 1ns / 1ps
// The result of an accepted input transaction is registered in the output register.
// Throughput: one transaction per cycle while in_ready_o is high; the framer state updates in the accepting cycle.
// in_ready_o drops only while a result sits in the output register and out_ready_i is low.
// Reset (rst_ni low, async): all framer state clears, payload buffer included,
// and timeout_q returns to 500.
module controller_packet_deframer_unit (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  cpd_pkg::cpd_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output cpd_pkg::cpd_out_t out_data_o,
  input  logic              cfg_we_i,
  input  logic [15:0]       cfg_data_i
);
  import cpd_pkg::*;

  // Configuration: idle ticks before a partial frame is thrown away.
  logic [15:0] timeout_q;

  // Framer state. A finished frame only reads payload bytes it wrote itself,
  // so the payload reset value never shows up in a result.
  cpd_state_t state_q;
  cpd_state_t state_d;
  cpd_out_t   result;
  logic       in_accept;

  assign in_accept = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q <= TIMEOUT_RESET;
    end else if (cfg_we_i) begin
      timeout_q <= cfg_data_i;
    end
  end

  // Whole framer state, cleared on reset, advanced once per input transaction.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else if (in_accept) begin
      state_q <= state_d;
    end
  end

  // One pass of framing logic per transaction.
  cpd_step u_step (
    .state_i   (state_q),
    .item_i    (in_data_i),
    .timeout_i (timeout_q),
    .state_o   (state_d),
    .result_o  (result)
  );

  // Output register decouples the result from the downstream handshake.
  cpd_out_reg u_out (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_valid_i),
    .ready_o (in_ready_o),
    .data_i  (result),
    .valid_o (out_valid_o),
    .ready_i (out_ready_i),
    .data_o  (out_data_o)
  );

`ifndef SYNTHESIS
  // The running index never goes past the buffer limit.
  a_index_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.byte_index <= 5'(FRAME_LIMIT))
    else $error("byte index beyond frame limit");

  // Done flag and kind agree on every result.
  a_done_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.packet_done == (out_data_o.packet_kind != KIND_NONE)))
    else $error("packet_done and packet_kind disagree");

  // An accepted acknowledge shows a cleared update flag in its result.
  a_ack_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_accept && in_data_i.command == CMD_ACK) |=>
      (out_valid_o && !out_data_o.update_flag))
    else $error("acknowledge did not clear update flag");

  // A timeout never coincides with a completed frame.
  a_tick_no_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.timed_out) |-> !out_data_o.packet_done)
    else $error("timeout reported on a completed frame");
`endif

endmodule

// ===== rtl/cpd_step.sv =====
`timescale 1ns / 1ps

module cpd_step (
  input  cpd_pkg::cpd_state_t state_i,
  input  cpd_pkg::cpd_in_t    item_i,
  input  logic [15:0]         timeout_i,
  output cpd_pkg::cpd_state_t state_o,
  output cpd_pkg::cpd_out_t   result_o
);
  import cpd_pkg::*;

  logic [4:0]  pos;
  logic [4:0]  idx_inc;
  logic [15:0] idle_inc;
  logic [7:0]  num_off;
  logic [7:0]  mask;
  logic        fired;
  kind_e       kind;

  always_comb begin
    state_o  = state_i;
    kind     = KIND_NONE;
    fired    = 1'b0;
    pos      = (item_i.rx_byte == CH_START) ? 5'd0 : state_i.byte_index;
    idx_inc  = pos + 5'd1;
    idle_inc = (state_i.idle_count == 16'hFFFF) ? state_i.idle_count
                                                 : state_i.idle_count + 16'd1;
    num_off  = state_i.payload[0] - CH_ONE;
    mask     = 8'd0;

    case (cmd_e'(item_i.command))
      CMD_BYTE: begin
        state_o.idle_count = 16'd0;
        if (state_i.byte_index < 5'(FRAME_LIMIT)) begin
          case (pos)
            5'd1: state_o.frame_type = item_i.rx_byte;
            5'd2: state_o.payload[0] = item_i.rx_byte;
            5'd3: state_o.payload[1] = item_i.rx_byte;
            5'd4: state_o.payload[2] = item_i.rx_byte;
            default: ;
          endcase
          state_o.byte_index = idx_inc;
          // completion uses the buffer as updated by this byte
          num_off = state_o.payload[0] - CH_ONE;
          mask    = 8'd1 << num_off[2:0];
          if (state_o.frame_type == CH_COLOR && idx_inc == LEN_COLOR) begin
            kind                = KIND_COLOR;
            state_o.red_level   = state_o.payload[0];
            state_o.green_level = state_o.payload[1];
            state_o.blue_level  = state_o.payload[2];
          end else if (state_o.frame_type == CH_BUTTON && idx_inc == LEN_BUTTON) begin
            kind = KIND_BUTTON;
            if (state_o.payload[0] inside {[CH_ONE:CH_EIGHT]}) begin
              if (state_o.payload[1] != CH_ZERO) begin
                state_o.pressed_buttons = state_i.pressed_buttons | mask;
              end else begin
                state_o.pressed_buttons = state_i.pressed_buttons & ~mask;
              end
            end
          end
          if (kind != KIND_NONE) begin
            state_o.byte_index     = 5'd0;
            state_o.frame_type     = 8'd0;
            state_o.update_pending = 1'b1;
          end
        end else begin
          // overflow: byte dropped, count restarts
          state_o.byte_index = 5'd0;
        end
      end
      CMD_TICK: begin
        state_o.idle_count = idle_inc;
        if (idle_inc >= timeout_i) begin
          fired              = (state_i.byte_index != 5'd0);
          state_o.byte_index = 5'd0;
          state_o.idle_count = 16'd0;
        end
      end
      CMD_ACK: state_o.update_pending = 1'b0;
      default: ;
    endcase

    result_o.packet_done = (kind != KIND_NONE);
    result_o.packet_kind = kind;
    result_o.color_red   = state_o.red_level;
    result_o.color_green = state_o.green_level;
    result_o.color_blue  = state_o.blue_level;
    result_o.button_bits = state_o.pressed_buttons;
    result_o.update_flag = state_o.update_pending;
    result_o.timed_out   = fired;
  end

endmodule

// ===== rtl/cpd_out_reg.sv =====
`timescale 1ns / 1ps

module cpd_out_reg (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  output logic              ready_o,
  input  cpd_pkg::cpd_out_t data_i,
  output logic              valid_o,
  input  logic              ready_i,
  output cpd_pkg::cpd_out_t data_o
);
  import cpd_pkg::*;

  logic     valid_q;
  cpd_out_t data_q;

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_i;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

// ===== sim/cpd_frame_checker.sv =====
`timescale 1ns / 1ps

module cpd_frame_checker (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_ready_i,
  input  cpd_pkg::cpd_in_t  in_data_i,
  input  logic              out_valid_i,
  input  logic              out_ready_i,
  input  cpd_pkg::cpd_out_t out_data_i,
  input  logic              cfg_we_i,
  input  logic [15:0]       cfg_data_i,
  output int unsigned       mismatch_count_o,
  output int unsigned       pending_results_o
);
  import cpd_pkg::*;

  // Framer state as seen from outside
  logic [15:0] timeout_limit;
  logic [4:0]  cur_index;
  logic [7:0]  cur_type;
  logic [7:0]  payload_buf [3];
  logic [15:0] idle_ticks;
  logic [7:0]  red_lvl, green_lvl, blue_lvl;
  logic [7:0]  buttons;
  logic        upd_pending;

  cpd_out_t    expected_results [$];
  int unsigned mismatch_total = 0;
  int unsigned pending_total = 0;

  assign mismatch_count_o  = mismatch_total;
  assign pending_results_o = pending_total;

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at %0t: %s", $realtime, msg);
    mismatch_total++;
  endtask

  task automatic check_field(input string name, input logic [7:0] got, input logic [7:0] want);
    if (got !== want) report_mismatch($sformatf("%s got %h want %h", name, got, want));
  endtask

  function automatic cpd_out_t apply_event(input cpd_in_t ev);
    cpd_out_t   res;
    kind_e      kind;
    logic       fired;
    logic [7:0] button_no;
    kind  = KIND_NONE;
    fired = 1'b0;
    case (ev.command)
      CMD_BYTE: begin
        idle_ticks = '0;
        if (cur_index < FRAME_LIMIT) begin
          // start char resyncs at any position below the buffer limit
          if (ev.rx_byte == CH_START) cur_index = '0;
          if (cur_index == 5'd1) cur_type = ev.rx_byte;
          else if (cur_index >= 5'd2 && cur_index <= 5'd4)
            payload_buf[2'(cur_index - 5'd2)] = ev.rx_byte;
          cur_index = cur_index + 5'd1;
          if (cur_type == CH_COLOR && cur_index == LEN_COLOR) begin
            red_lvl   = payload_buf[0];
            green_lvl = payload_buf[1];
            blue_lvl  = payload_buf[2];
            kind      = KIND_COLOR;
          end else if (cur_type == CH_BUTTON && cur_index == LEN_BUTTON) begin
            button_no = payload_buf[0] - CH_ZERO;
            if (button_no >= 8'd1 && button_no <= 8'd8) begin
              if (payload_buf[1] != CH_ZERO) buttons |= 8'd1 << (button_no - 8'd1);
              else buttons &= ~(8'd1 << (button_no - 8'd1));
            end
            kind = KIND_BUTTON;
          end
          if (kind != KIND_NONE) begin
            cur_index   = '0;
            cur_type    = '0;
            upd_pending = 1'b1;
          end
        end else begin
          // buffer full: byte dropped
          cur_index = '0;
        end
      end
      CMD_TICK: begin
        if (idle_ticks != 16'hFFFF) idle_ticks = idle_ticks + 16'd1;
        if (idle_ticks >= timeout_limit) begin
          fired      = (cur_index != '0);
          cur_index  = '0;
          idle_ticks = '0;
        end
      end
      CMD_ACK: upd_pending = 1'b0;
      default: ;
    endcase
    res.packet_done = (kind != KIND_NONE);
    res.packet_kind = kind;
    res.color_red   = red_lvl;
    res.color_green = green_lvl;
    res.color_blue  = blue_lvl;
    res.button_bits = buttons;
    res.update_flag = upd_pending;
    res.timed_out   = fired;
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    cpd_out_t want;
    if (!rst_ni) begin
      timeout_limit = TIMEOUT_RESET;
      cur_index     = '0;
      cur_type      = '0;
      payload_buf   = '{default: '0};
      idle_ticks    = '0;
      red_lvl       = '0;
      green_lvl     = '0;
      blue_lvl      = '0;
      buttons       = '0;
      upd_pending   = 1'b0;
      expected_results.delete();
      pending_total <= 0;
    end else begin
      if (cfg_we_i) timeout_limit = cfg_data_i;
      if (in_valid_i && in_ready_i) expected_results.push_back(apply_event(in_data_i));
      if (out_valid_i && out_ready_i) begin
        if (expected_results.size() == 0) begin
          report_mismatch("result transaction with nothing expected");
        end else begin
          want = expected_results.pop_front();
          check_field("packet_done", 8'(out_data_i.packet_done), 8'(want.packet_done));
          check_field("packet_kind", 8'(out_data_i.packet_kind), 8'(want.packet_kind));
          check_field("color_red", out_data_i.color_red, want.color_red);
          check_field("color_green", out_data_i.color_green, want.color_green);
          check_field("color_blue", out_data_i.color_blue, want.color_blue);
          check_field("button_bits", out_data_i.button_bits, want.button_bits);
          check_field("update_flag", 8'(out_data_i.update_flag), 8'(want.update_flag));
          check_field("timed_out", 8'(out_data_i.timed_out), 8'(want.timed_out));
        end
      end
      pending_total <= expected_results.size();
    end
  end

endmodule

// ===== sim/controller_packet_deframer_unit_tb.sv =====
`timescale 1ns / 1ps

module controller_packet_deframer_unit_tb;
  import cpd_pkg::*;

  logic        clk_i     = 1'b0;
  logic        rst_ni    = 1'b0;
  logic        in_valid  = 1'b0;
  cpd_in_t     in_data   = '0;
  logic        in_ready;
  logic        out_valid;
  logic        out_ready = 1'b0;
  cpd_out_t    out_data;
  logic        cfg_we    = 1'b0;
  logic [15:0] cfg_data  = '0;

  int unsigned mismatch_count;
  int unsigned pending_results;

  // sender bookkeeping
  int unsigned items_sent  = 0;
  logic [15:0] cur_timeout = TIMEOUT_RESET;

  always #1 clk_i = ~clk_i;

  controller_packet_deframer_unit i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data),
    .cfg_we_i    (cfg_we),
    .cfg_data_i  (cfg_data)
  );

  // Watches both channels and the config port, predicts and compares.
  cpd_frame_checker i_checker (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid),
    .in_ready_i        (in_ready),
    .in_data_i         (in_data),
    .out_valid_i       (out_valid),
    .out_ready_i       (out_ready),
    .out_data_i        (out_data),
    .cfg_we_i          (cfg_we),
    .cfg_data_i        (cfg_data),
    .mismatch_count_o  (mismatch_count),
    .pending_results_o (pending_results)
  );

  function automatic cpd_in_t pack_event(input cmd_e c, input logic [7:0] b);
    cpd_in_t ev;
    ev.command = c;
    ev.rx_byte = b;
    return ev;
  endfunction

  // Offer one input transaction and hold it until accepted. Random gaps
  // before the offer, except in a steady window in the middle of the run.
  task automatic offer(input cpd_in_t ev);
    if (items_sent < 1300 || items_sent >= 1650) begin
      while ($urandom_range(99) < 19) begin
        in_valid <= 1'b0;
        @(posedge clk_i);
      end
    end
    in_valid <= 1'b1;
    in_data  <= ev;
    do @(posedge clk_i); while (!in_ready);
    items_sent++;
  endtask

  task automatic put_byte(input logic [7:0] b);
    offer(pack_event(CMD_BYTE, b));
  endtask

  // Non-byte commands carry a random don't-care byte.
  task automatic put_cmd(input cmd_e c);
    offer(pack_event(c, 8'($urandom_range(255))));
  endtask

  // Occasional tick / ack / nop wedged into a frame.
  task automatic maybe_stray();
    if ($urandom_range(9) == 0) put_cmd(cmd_e'($urandom_range(1, 3)));
  endtask

  // Stop offering until every expected result has come back.
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk_i); while (pending_results != 0);
    repeat (2) @(posedge clk_i);
  endtask

  task automatic set_timeout(input logic [15:0] v);
    cfg_we   <= 1'b1;
    cfg_data <= v;
    @(posedge clk_i);
    cfg_we      <= 1'b0;
    cur_timeout = v;
  endtask

  // One random sequence: mostly well-formed frames with random content,
  // plus timeout runs, buffer overflows and raw noise.
  task automatic random_burst();
    int unsigned pick, n;
    logic [7:0]  b;
    pick = $urandom_range(99);
    if (pick < 40) begin
      // colour frame
      put_byte(CH_START);
      maybe_stray();
      put_byte(CH_COLOR);
      repeat (3) begin
        maybe_stray();
        put_byte(8'($urandom_range(255)));
      end
      put_byte(8'($urandom_range(255)));
    end else if (pick < 70) begin
      // button frame; mostly valid digits, sometimes out of range
      put_byte(CH_START);
      put_byte(CH_BUTTON);
      maybe_stray();
      case ($urandom_range(9))
        0:       b = CH_ZERO;
        1:       b = CH_EIGHT + 8'd1;
        2:       b = 8'($urandom_range(255));
        default: b = 8'($urandom_range(CH_ONE, CH_EIGHT));
      endcase
      put_byte(b);
      put_byte($urandom_range(1) ? CH_ZERO : 8'($urandom_range(255)));
      maybe_stray();
      put_byte(8'($urandom_range(255)));
    end else if (pick < 80) begin
      // partial frame followed by ticks, enough to time out when the timeout is 32 or less
      put_byte(CH_START);
      repeat ($urandom_range(3)) put_byte(8'($urandom_range(255)));
      n = (cur_timeout <= 16'd32) ? cur_timeout + $urandom_range(2) : $urandom_range(1, 5);
      repeat (n) put_cmd(CMD_TICK);
    end else if (pick < 85) begin
      // run up to or past the buffer limit with no start char and no valid type
      put_byte(CH_START);
      do b = 8'($urandom_range(255));
      while (b == CH_START || b == CH_BUTTON || b == CH_COLOR);
      put_byte(b);
      repeat ($urandom_range(FRAME_LIMIT - 2, FRAME_LIMIT + 3)) begin
        do b = 8'($urandom_range(255)); while (b == CH_START);
        put_byte(b);
      end
    end else begin
      // noise over the whole command space
      repeat ($urandom_range(1, 6))
        offer(pack_event(cmd_e'($urandom_range(3)), 8'($urandom_range(255))));
    end
  endtask

  task automatic run_random(input int unsigned count);
    int unsigned stop_at;
    stop_at = items_sent + count;
    while (items_sent < stop_at) random_burst();
  endtask

  // Receiver: random stalls, one long hold-off early on (output register
  // fills, input stalls while the sender keeps offering), then a stretch
  // that is always ready.
  initial begin
    int unsigned cyc;
    cyc = 0;
    forever begin
      @(posedge clk_i);
      cyc++;
      if (cyc >= 150 && cyc < 300) out_ready <= 1'b0;
      else if (cyc >= 1500 && cyc < 2100) out_ready <= 1'b1;
      else out_ready <= ($urandom_range(99) >= 19);
    end
  end

  // Sender and verdict
  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: colour extremes, ack, nop, button set, restart mid-frame
    // with an out-of-range button digit, lone tick.
    put_byte(CH_START);
    put_byte(CH_COLOR);
    put_byte(8'h00);
    put_byte(8'hFF);
    put_byte(8'h80);
    put_byte(8'h5A);
    put_cmd(CMD_ACK);
    put_cmd(CMD_NOP);
    put_byte(CH_START);
    put_byte(CH_BUTTON);
    put_byte(CH_EIGHT);
    put_byte(CH_ONE);
    put_byte(8'hFF);
    put_byte(CH_START);
    put_byte(CH_BUTTON);
    put_byte(CH_START);
    put_byte(CH_BUTTON);
    put_byte(CH_ZERO);
    put_byte(CH_ONE);
    put_byte(8'h00);
    put_cmd(CMD_TICK);

    // Timeout at the reset value: one tick short, then the one that fires.
    put_byte(CH_START);
    put_byte(CH_COLOR);
    repeat (TIMEOUT_RESET) put_cmd(CMD_TICK);
    drain();

    // Zero timeout: every tick times out.
    set_timeout(16'd0);
    put_byte(CH_START);
    put_cmd(CMD_TICK);
    put_cmd(CMD_TICK);
    run_random(100);
    drain();

    set_timeout(16'd1);
    run_random(150);
    drain();

    set_timeout(16'hFFFF);
    run_random(150);
    drain();

    repeat (4) begin
      set_timeout(16'($urandom_range(2, 12)));
      run_random(200);
      drain();
    end

    repeat (4) @(posedge clk_i);
    if (mismatch_count == 0 && pending_results == 0) begin
      $display("controller_packet_deframer_unit verification clean");
    end else begin
      $display("controller_packet_deframer_unit verification failed");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #1000000;
    $display("controller_packet_deframer_unit verification failed");
    $finish;
  end

endmodule
